/* hw/rtl/aks_pkg.sv */
// Package with shared types, constants and the byte substitution for the AES key schedule.
`timescale 1ns / 1ps
package aks_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned ChunkW = 64;
	localparam int unsigned WinD   = 8;

	localparam logic [1:0] ModeK256 = 2'd2;
	localparam logic [7:0] RconInit = 8'h01;
	localparam logic [7:0] GfPoly   = 8'h1B;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic [1:0] slot;
		logic       init;
		logic       step;
		logic       gen;
		logic       pos_zero;
		logic       pos_four;
		logic       emit;
		logic       last;
		logic [4:0] pair_idx;
		logic [3:0] nk;
	} aks_cmd_t;

	function automatic logic [31:0] sub_word(input logic [31:0] x);
		sub_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

endpackage

/* hw/rtl/aks_ctrl.sv */
// Controller state machine: chunk counting, key length and word sequencing.
`timescale 1ns / 1ps
module aks_ctrl import aks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_mode,
	output logic        busy,
	output aks_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} st_t;

	st_t        state_q;
	logic [1:0] mode_q;
	logic [2:0] chunks_q;
	logic [5:0] idx_q;
	logic [3:0] pos_q;
	logic [3:0] nk_q;
	logic [5:0] total_q;

	logic [1:0] mode_sat;
	logic [3:0] nk_cur;
	logic [2:0] chunks_n;
	logic       accept;
	logic       done_key;
	logic       run;
	logic       last_word;

	assign mode_sat  = (mode_q > ModeK256) ? ModeK256 : mode_q;
	assign nk_cur    = 4'd4 + {1'b0, mode_sat, 1'b0};
	assign accept    = start && (state_q == ST_IDLE);
	assign chunks_n  = chunks_q + 3'd1;
	assign done_key  = {1'b0, chunks_n} >= {1'b0, nk_cur[3:1]};
	assign run       = (state_q == ST_RUN);
	assign last_word = (idx_q == total_q - 6'd1);
	assign busy      = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= 2'd0;
			chunks_q <= 3'd0;
			idx_q    <= 6'd0;
			pos_q    <= 4'd0;
			nk_q     <= 4'd4;
			total_q  <= 6'd44;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_mode;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (done_key) begin
							chunks_q <= 3'd0;
							idx_q    <= 6'd0;
							pos_q    <= 4'd0;
							nk_q     <= nk_cur;
							total_q  <= 6'({nk_cur, 2'b00} + 6'd28);
							state_q  <= ST_RUN;
						end else begin
							chunks_q <= chunks_n;
						end
					end
				end
				ST_RUN: begin
					idx_q <= idx_q + 6'd1;
					pos_q <= (pos_q == nk_q - 4'd1) ? 4'd0 : pos_q + 4'd1;
					if (last_word) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load     = accept;
		cmd.slot     = chunks_q[1:0];
		cmd.init     = accept && done_key;
		cmd.step     = run;
		cmd.gen      = {2'b00, idx_q} >= {4'b0000, nk_q};
		cmd.pos_zero = (pos_q == 4'd0);
		cmd.pos_four = (pos_q == 4'd4) && (nk_q == 4'd8);
		cmd.emit     = run && idx_q[0];
		cmd.last     = last_word;
		cmd.pair_idx = idx_q[5:1];
		cmd.nk       = nk_q;
	end

endmodule

/* hw/rtl/aks_dp.sv */
// Datapath: word window, round constant, word pairing and result registers.
`timescale 1ns / 1ps
module aks_dp import aks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  aks_cmd_t    cmd,
	input  logic [63:0] key_chunk,
	output logic        result_strobe,
	output logic [63:0] round_key_half,
	output logic [4:0]  pair_index,
	output logic        last_pair
);

	logic [31:0] win_q [WinD];
	logic [7:0]  rcon_q;
	logic [31:0] prev_q;
	logic        strobe_q;

	logic [31:0] tail_w;
	logic [31:0] temp_w;
	logic [31:0] new_w;
	logic [31:0] word_w;
	logic [31:0] rot_w;

	always_comb begin
		tail_w = win_q[3'(cmd.nk - 4'd1)];
		rot_w  = {tail_w[23:0], tail_w[31:24]};
		temp_w = tail_w;
		if (cmd.pos_zero) begin
			temp_w = sub_word(rot_w) ^ {rcon_q, 24'h0};
		end else if (cmd.pos_four) begin
			temp_w = sub_word(tail_w);
		end
		new_w  = win_q[0] ^ temp_w;
		word_w = cmd.gen ? new_w : win_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < WinD; j++) begin
				win_q[j] <= '0;
			end
			rcon_q   <= RconInit;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.step && cmd.emit;
			if (cmd.init) begin
				rcon_q <= RconInit;
			end else if (cmd.step && cmd.gen && cmd.pos_zero) begin
				rcon_q <= {rcon_q[6:0], 1'b0} ^ (rcon_q[7] ? GfPoly : 8'h00);
			end
			if (cmd.load) begin
				win_q[{cmd.slot, 1'b0}] <= key_chunk[63:32];
				win_q[{cmd.slot, 1'b1}] <= key_chunk[31:0];
			end else if (cmd.step) begin
				// Key words rotate through the window once, then new words shift in.
				for (int j = 0; j < WinD; j++) begin
					if (4'(j) < cmd.nk - 4'd1) begin
						win_q[j] <= win_q[(j + 1) % WinD];
					end else if (4'(j) == cmd.nk - 4'd1) begin
						win_q[j] <= word_w;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			prev_q <= word_w;
			if (cmd.emit) begin
				round_key_half <= {prev_q, word_w};
				pair_index     <= cmd.pair_idx;
				last_pair      <= cmd.last;
			end
		end
	end

	assign result_strobe = strobe_q;

endmodule

/* hw/rtl/aes_key_expansion_top.sv */
// Top level of the AES key schedule engine for 128-, 192- and 256-bit keys.
`timescale 1ns / 1ps
//  Channel   | Signals                                        | Transfer
//  ----------+------------------------------------------------+---------------------------
//  key in    | start, busy, key_chunk                         | start && !busy
//  config    | cfg_valid, cfg_ready, cfg_data                 | cfg_valid && cfg_ready
//  result    | result_strobe, round_key_half, pair_index,     | every cycle result_strobe
//            | last_pair                                      | is high
//
// The chunk that completes a key starts a run that yields 4*Nk+28 schedule
// words (44, 52 or 60), one word per cycle from the word window and its single
// expansion unit; a pair leaves after every second word. busy stays high for
// the run. Reset clears the window, counters and mode. The receiver cannot
// stall; each result is registered and shown in the cycle after its pair forms.
module aes_key_expansion_top import aks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] key_chunk,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	output logic        result_strobe,
	output logic [63:0] round_key_half,
	output logic [4:0]  pair_index,
	output logic        last_pair
);

	aks_cmd_t cmd;

	// The mode register always takes a write; the user must write it only while idle, as the block does not enforce it.
	assign cfg_ready = 1'b1;

	aks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cfg_we   (cfg_valid),
		.cfg_mode (cfg_data),
		.busy     (busy),
		.cmd      (cmd)
	);

	aks_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.key_chunk      (key_chunk),
		.result_strobe  (result_strobe),
		.round_key_half (round_key_half),
		.pair_index     (pair_index),
		.last_pair      (last_pair)
	);

	// A result is only produced from a word computed during a run.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy)) else $error("result outside a run");

	// Every pair index fits the longest schedule.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (pair_index <= 5'd29)) else $error("pair index out of range");

	// The end-of-schedule mark closes the run.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_pair) |-> !busy) else $error("run continues after last pair");

endmodule
